[design/egel_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package egel_pkg;

  localparam int DENS_W    = 17;
  localparam int EXP_TERMS = 16;

  // floor(2^32 / n) for the series divisors; entries 0 and 1 are not used.
  localparam logic [31:0] RECIP_TAB [17] = '{
    32'd0,          32'd0,          32'd2147483648, 32'd1431655765,
    32'd1073741824, 32'd858993459,  32'd715827882,  32'd613566756,
    32'd536870912,  32'd477218588,  32'd429496729,  32'd390451572,
    32'd357913941,  32'd330382099,  32'd306783378,  32'd286331153,
    32'd268435456
  };

  typedef struct packed {
    logic valid;
    logic zero;
  } expo_ctl_t;

endpackage
`default_nettype wire

[design/egel_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module egel_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_vld,
  input  wire logic signed [32:0]           in_diff,
  input  wire logic [30:0]                  width,
  output logic                              out_vld,
  output logic signed [FRAC_BITS+7:0]       out_t
);
  import egel_pkg::*;

  localparam int TW = FRAC_BITS + 8;

  logic            vld_r [TW+2];
  logic [30:0]     rem_r [TW+1];
  logic [7:0]      low_r [TW+1];
  logic [TW-1:0]   quo_r [TW+1];
  logic            neg_r [TW+1];
  logic            sat_r [TW+1];
  logic signed [TW-1:0] t_r;

  logic [32:0]     mag;
  logic [24:0]     mag_hi;

  assign mag    = in_diff[32] ? 33'(-in_diff) : 33'(in_diff);
  assign mag_hi = mag[32:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TW + 2; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < TW + 2; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Quotients of 2^(TW) or more saturate, so only TW quotient bits are formed.
  always_ff @(posedge clk) begin
    rem_r[0] <= mag_hi[24:0] >= 25'(width) && width[30:25] == 6'd0 ? 31'd0 : 31'(mag_hi);
    low_r[0] <= mag[7:0];
    quo_r[0] <= '0;
    neg_r[0] <= in_diff[32];
    sat_r[0] <= (mag != 33'd0) && (32'(mag_hi) >= 32'(width));
  end

  // A zero width forms a zero quotient, so a zero difference gives t = 0 and any
  // other difference is caught by the saturation flag.
  for (genvar j = 0; j < TW; j++) begin : g_step
    logic [31:0] trial;
    logic        fits;
    assign trial = {rem_r[j], low_r[j][7]};
    assign fits  = (width != 31'd0) && (trial >= 32'(width));
    always_ff @(posedge clk) begin
      rem_r[j+1] <= fits ? 31'(trial - 32'(width)) : trial[30:0];
      low_r[j+1] <= {low_r[j][6:0], 1'b0};
      quo_r[j+1] <= {quo_r[j][TW-2:0], fits};
      neg_r[j+1] <= neg_r[j];
      sat_r[j+1] <= sat_r[j];
    end
  end

  localparam logic [TW-1:0] TNEG = TW'(1) << (TW - 1);
  localparam logic [TW-1:0] TMAX = TNEG - TW'(1);

  always_ff @(posedge clk) begin
    if (neg_r[TW]) begin
      t_r <= (sat_r[TW] || quo_r[TW] > TNEG) ? $signed(TNEG) : $signed(TW'(-quo_r[TW]));
    end else begin
      t_r <= (sat_r[TW] || quo_r[TW] > TMAX) ? $signed(TMAX) : $signed(quo_r[TW]);
    end
  end

  assign out_vld = vld_r[TW+1];
  assign out_t   = t_r;

endmodule
`default_nettype wire

[design/egel_expo.sv]
`timescale 1ns / 1ps
`default_nettype none
module egel_expo #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire logic signed [FRAC_BITS+7:0] in_t,
  input  wire logic [20:0]                 low_k,
  input  wire logic [20:0]                 high_k,
  output egel_pkg::expo_ctl_t              out_ctl,
  output logic [35:0]                      out_a
);
  import egel_pkg::*;

  localparam int TW = FRAC_BITS + 8;
  localparam int CW = ((TW > 21) ? TW : 21) + 2;
  localparam int XW = ((2 * TW > 44) ? 2 * TW : 44) + 2;
  localparam int SH = 2 * FRAC_BITS + 1 - 32;
  localparam logic signed [XW-1:0] LIM = XW'(24) <<< (2 * FRAC_BITS);

  logic [3:0]               vld_r;
  logic signed [TW-1:0]     t_r;
  logic                     lo_r, hi_r, lo2_r, hi2_r, zero_r;
  logic [20:0]              k_r;
  logic [41:0]              kk_r;
  logic signed [TW+21:0]    kt_r;
  logic signed [2*TW-1:0]   tt_r;
  logic signed [XW-1:0]     x2_r;
  logic [35:0]              a_r;

  logic signed [CW-1:0]     t_ext, lk_ext, hk_ext;
  logic signed [XW-1:0]     kt2, kkx, x2_nxt;
  logic [XW-1:0]            ux;

  assign t_ext  = CW'(in_t);
  assign lk_ext = CW'($signed({1'b0, low_k}));
  assign hk_ext = CW'($signed({1'b0, high_k}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    t_r  <= in_t;
    lo_r <= t_ext < -lk_ext;
    hi_r <= t_ext > hk_ext;
    k_r  <= (t_ext < -lk_ext) ? low_k : high_k;
  end

  always_ff @(posedge clk) begin
    kk_r  <= 42'(k_r) * 42'(k_r);
    kt_r  <= (TW+22)'(t_r) * (TW+22)'($signed({1'b0, k_r}));
    tt_r  <= (2*TW)'(t_r) * (2*TW)'(t_r);
    lo2_r <= lo_r;
    hi2_r <= hi_r;
  end

  assign kt2 = XW'(kt_r) <<< 1;
  assign kkx = $signed(XW'(kk_r));

  always_comb begin
    if (lo2_r) begin
      x2_nxt = -(kkx + kt2);
    end else if (hi2_r) begin
      x2_nxt = kt2 - kkx;
    end else begin
      x2_nxt = XW'(tt_r);
    end
  end

  always_ff @(posedge clk) begin
    x2_r <= x2_nxt;
  end

  assign ux = x2_r[XW-1] ? '0 : x2_r;

  if (SH >= 0) begin : g_rsh
    always_ff @(posedge clk) begin
      a_r    <= 36'(ux >> SH);
      zero_r <= x2_r > LIM;
    end
  end else begin : g_lsh
    always_ff @(posedge clk) begin
      a_r    <= 36'(ux << (-SH));
      zero_r <= x2_r > LIM;
    end
  end

  assign out_ctl.valid = vld_r[3];
  assign out_ctl.zero  = zero_r;
  assign out_a         = a_r;

endmodule
`default_nettype wire

[design/egel_exp.sv]
`timescale 1ns / 1ps
`default_nettype none
module egel_exp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire egel_pkg::expo_ctl_t  in_ctl,
  input  wire logic [35:0]          in_a,
  output logic                      out_vld,
  output logic [egel_pkg::DENS_W-1:0] out_density
);
  import egel_pkg::*;

  // Stage 0 loads, three stages per series term, one clamps the sum, four squarings,
  // one rounding.
  localparam int NST = 1 + 3 * EXP_TERMS + 1 + 4 + 1;

  expo_ctl_t          ctl_r [NST];
  logic [29:0]        u_r   [EXP_TERMS+1];
  logic [30:0]        term_r[EXP_TERMS+1];
  logic signed [32:0] s_r   [EXP_TERMS+1];
  logic [30:0]        sq_r  [5];
  logic [DENS_W-1:0]  dens_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) ctl_r[i] <= '0;
    end else begin
      ctl_r[0] <= in_ctl;
      for (int i = 1; i < NST; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  // exp(-a) is taken as exp(-a/16) to the sixteenth power.
  always_ff @(posedge clk) begin
    u_r[0]    <= in_a[35:6];
    term_r[0] <= 31'(1) << 30;
    s_r[0]    <= 33'(1) << 30;
  end

  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
    localparam int N = j + 1;
    logic [29:0]        p_a_r, u_a_r, p_b_r, u_b_r, q0_r;
    logic signed [32:0] s_a_r, s_b_r;
    logic [60:0]        prod;
    logic [61:0]        prod2;
    logic [34:0]        back;
    logic [29:0]        rem;
    logic [30:0]        q;

    assign prod = 61'(term_r[j]) * 61'(u_r[j]);

    always_ff @(posedge clk) begin
      p_a_r <= prod[59:30];
      u_a_r <= u_r[j];
      s_a_r <= s_r[j];
    end

    if (N == 1) begin : g_unit
      assign prod2 = '0;
      always_ff @(posedge clk) begin
        q0_r <= p_a_r;
      end
    end else begin : g_recip
      assign prod2 = 62'(p_a_r) * 62'(RECIP_TAB[N]);
      always_ff @(posedge clk) begin
        q0_r <= prod2[61:32];
      end
    end

    always_ff @(posedge clk) begin
      p_b_r <= p_a_r;
      u_b_r <= u_a_r;
      s_b_r <= s_a_r;
    end

    // The reciprocal estimate is at most one below the true quotient.
    assign back = 35'(q0_r) * 35'(N);
    assign rem  = 30'(35'(p_b_r) - back);
    assign q    = (rem >= 30'(N)) ? 31'(q0_r) + 31'd1 : 31'(q0_r);

    always_ff @(posedge clk) begin
      u_r[j+1]    <= u_b_r;
      term_r[j+1] <= q;
      s_r[j+1]    <= (N % 2 == 1) ? s_b_r - $signed(33'(q)) : s_b_r + $signed(33'(q));
    end
  end

  always_ff @(posedge clk) begin
    sq_r[0] <= s_r[EXP_TERMS][32] ? 31'd0 : s_r[EXP_TERMS][30:0];
  end

  for (genvar k = 0; k < 4; k++) begin : g_sq
    logic [61:0] sq;
    assign sq = 62'(sq_r[k]) * 62'(sq_r[k]) + (62'(1) << 29);
    always_ff @(posedge clk) begin
      sq_r[k+1] <= sq[60:30];
    end
  end

  logic [31:0] rnd;
  assign rnd = 32'(sq_r[4]) + (32'(1) << 13);

  always_ff @(posedge clk) begin
    if (ctl_r[NST-2].zero) begin
      dens_r <= '0;
    end else if (rnd[31:14] > 18'd65536) begin
      dens_r <= DENS_W'(65536);
    end else begin
      dens_r <= rnd[30:14];
    end
  end

  assign out_vld     = ctl_r[NST-1].valid;
  assign out_density = dens_r;

endmodule
`default_nettype wire

[design/exp_gauss_exp_lineshape_eval_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Depth: one restoring divider stage per quotient bit and three stages per exponential
// series term set the pipeline depth from the start transfer to the out_valid strobe.
// Throughput: one sample per cycle; busy stays low and results cannot be stalled.
// Reset: synchronous, active low; clears the pipeline valid bits and loads the
// register defaults (centre 0, width 1.0, both tail bounds 2.0).
module exp_gauss_exp_lineshape_eval_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [31:0]           in_sample_value,
  output logic                              out_valid,
  output logic [egel_pkg::DENS_W-1:0]       out_density,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [3:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import egel_pkg::*;

  localparam int TW = FRAC_BITS + 8;
  localparam logic [1:0] REG_CENTER = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_LOW_K  = 2'd2;
  localparam logic [1:0] REG_HIGH_K = 2'd3;

  logic signed [31:0] cfg_center_r;
  logic [30:0]        cfg_width_r;
  logic [20:0]        cfg_low_k_r;
  logic [20:0]        cfg_high_k_r;
  logic               wr_en;

  logic               d_vld_r;
  logic signed [32:0] d_r;
  logic               t_vld;
  logic signed [TW-1:0] t_val;
  expo_ctl_t          e_ctl;
  logic [35:0]        e_a;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_center_r <= '0;
      cfg_width_r  <= 31'(1) << FRAC_BITS;
      cfg_low_k_r  <= 21'(64'(2) << FRAC_BITS);
      cfg_high_k_r <= 21'(64'(2) << FRAC_BITS);
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_CENTER: cfg_center_r <= $signed(pwdata);
        REG_WIDTH:  cfg_width_r  <= pwdata[30:0];
        REG_LOW_K:  cfg_low_k_r  <= pwdata[20:0];
        REG_HIGH_K: cfg_high_k_r <= pwdata[20:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CENTER: prdata = cfg_center_r;
      REG_WIDTH:  prdata = 32'(cfg_width_r);
      REG_LOW_K:  prdata = 32'(cfg_low_k_r);
      REG_HIGH_K: prdata = 32'(cfg_high_k_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= 33'(in_sample_value) - 33'(cfg_center_r);
  end

  egel_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (d_vld_r),
    .in_diff (d_r),
    .width   (cfg_width_r),
    .out_vld (t_vld),
    .out_t   (t_val)
  );

  egel_expo #(.FRAC_BITS(FRAC_BITS)) u_expo (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (t_vld),
    .in_t    (t_val),
    .low_k   (cfg_low_k_r),
    .high_k  (cfg_high_k_r),
    .out_ctl (e_ctl),
    .out_a   (e_a)
  );

  egel_exp u_exp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ctl      (e_ctl),
    .in_a        (e_a),
    .out_vld     (out_valid),
    .out_density (out_density)
  );

endmodule
`default_nettype wire

[design/egel_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
module egel_chk #(
  parameter int FRAC_BITS = 16
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [16:0] out_density,
  input wire logic        pready
);
  localparam int LAT = FRAC_BITS + 70;

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_dens_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_density <= 17'd65536)
    else $error("density above 1.0");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a matching transfer");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind exp_gauss_exp_lineshape_eval_core egel_chk #(.FRAC_BITS(FRAC_BITS)) u_egel_chk (.*);
`default_nettype wire

[bench/egel_checker.sv]
`timescale 1ns / 1ps
module egel_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic signed [31:0] in_sample_value,
  input  logic              out_valid,
  input  logic [egel_pkg::DENS_W-1:0] out_density,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending,
  output int                n_low_tail,
  output int                n_core,
  output int                n_high_tail
);

  localparam logic [3:0] ADDR_CENTER = 4'd0;
  localparam logic [3:0] ADDR_WIDTH  = 4'd4;
  localparam logic [3:0] ADDR_LO_K   = 4'd8;
  localparam logic [3:0] ADDR_HI_K   = 4'd12;

  localparam int REGION_LOW  = 0;
  localparam int REGION_CORE = 1;
  localparam int REGION_HIGH = 2;

  longint          centre_q;
  longint unsigned width_q;
  longint          lo_k_q;
  longint          hi_k_q;

  logic [egel_pkg::DENS_W-1:0] density_queue[$];

  assign pending = density_queue.size();

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  // exp(-a) with a at 32 fractional bits, a <= 12; result at 30 fractional bits.
  function automatic longint unsigned exp_neg_q30(input longint unsigned a32);
    longint unsigned u, term, r;
    longint acc;
    int n;
    u = a32 >> 6;
    acc = longint'(1) << 30;
    term = longint'(1) << 30;
    for (n = 1; n <= 16; n++) begin
      term = ((term * u) >> 30) / longint'(n);
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    r = (acc < 0) ? 0 : longint'(acc);
    for (n = 0; n < 4; n++) r = (r * r + (longint'(1) << 29)) >> 30;
    return r;
  endfunction

  function automatic logic [egel_pkg::DENS_W-1:0] predict_density(
      input logic signed [31:0] s, output int region);
    longint tmax, t, x2, offs;
    longint unsigned tneg, mag, q, ux, a32, lim, r, dens;
    int sh;
    tmax = (longint'(1) << (FRAC_BITS + 7)) - 1;
    tneg = longint'(1) << (FRAC_BITS + 7);
    offs = longint'(s) - centre_q;
    mag = (offs < 0) ? -offs : offs;
    if (width_q == 0) begin
      t = (offs > 0) ? tmax : ((offs < 0) ? -longint'(tneg) : 0);
    end else begin
      q = (mag << FRAC_BITS) / width_q;
      if (offs < 0) t = (q > tneg) ? -longint'(tneg) : -longint'(q);
      else t = (q > tmax) ? tmax : longint'(q);
    end
    if (t < -lo_k_q) begin
      region = REGION_LOW;
      x2 = -(lo_k_q * lo_k_q + 2 * lo_k_q * t);
    end else if (t > hi_k_q) begin
      region = REGION_HIGH;
      x2 = 2 * hi_k_q * t - hi_k_q * hi_k_q;
    end else begin
      region = REGION_CORE;
      x2 = t * t;
    end
    ux = (x2 < 0) ? 0 : x2;
    lim = longint'(24) << (2 * FRAC_BITS);
    if (ux > lim) begin
      dens = 0;
    end else begin
      sh = 2 * FRAC_BITS + 1 - 32;
      a32 = (sh >= 0) ? (ux >> sh) : (ux << (-sh));
      r = exp_neg_q30(a32);
      dens = (r + (longint'(1) << 13)) >> 14;
      if (dens > 65536) dens = 65536;
    end
    return dens[egel_pkg::DENS_W-1:0];
  endfunction

  initial begin
    fail_count = 0;
    n_low_tail = 0;
    n_core = 0;
    n_high_tail = 0;
  end

  always @(posedge clk) begin
    int region;
    logic [egel_pkg::DENS_W-1:0] want;
    if (!rst_n) begin
      centre_q <= 0;
      width_q <= longint'(1) << FRAC_BITS;
      lo_k_q <= longint'(2) << FRAC_BITS;
      hi_k_q <= longint'(2) << FRAC_BITS;
      density_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_CENTER: centre_q <= longint'(signed'(pwdata));
          ADDR_WIDTH:  width_q <= pwdata[30:0];
          ADDR_LO_K:   lo_k_q <= pwdata[20:0];
          ADDR_HI_K:   hi_k_q <= pwdata[20:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (density_queue.size() == 0) begin
          report_mismatch($sformatf("density %0d with nothing outstanding", out_density));
        end else begin
          want = density_queue.pop_front();
          if (out_density !== want)
            report_mismatch($sformatf("density %0d, predicted %0d", out_density, want));
        end
      end
      // The transfer is predicted with the settings in force before this edge.
      if (start && !busy) begin
        want = predict_density(in_sample_value, region);
        density_queue.push_back(want);
        case (region)
          REGION_LOW:  n_low_tail++;
          REGION_HIGH: n_high_tail++;
          default:     n_core++;
        endcase
      end
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY   = FRAC_BITS + 70;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 112;

  localparam logic [3:0] ADDR_CENTER = 4'd0;
  localparam logic [3:0] ADDR_WIDTH  = 4'd4;
  localparam logic [3:0] ADDR_LO_K   = 4'd8;
  localparam logic [3:0] ADDR_HI_K   = 4'd12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic signed [31:0] in_sample_value = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy;
  logic out_valid;
  logic [egel_pkg::DENS_W-1:0] out_density;
  logic [31:0] prdata;
  logic pready;

  int fail_count, pending, n_low_tail, n_core, n_high_tail;
  int samples_sent = 0;
  int settings_used = 1;
  int burst_left = 0;
  logic signed [31:0] centre_now = '0;
  logic [31:0] width_now = 32'd65536;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  exp_gauss_exp_lineshape_eval_core #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_value(in_sample_value), .out_valid(out_valid), .out_density(out_density),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  egel_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_value(in_sample_value), .out_valid(out_valid), .out_density(out_density),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .fail_count(fail_count), .pending(pending),
    .n_low_tail(n_low_tail), .n_core(n_core), .n_high_tail(n_high_tail)
  );

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  // The bus is left selected after the access edge; the caller releases it once
  // the last write is done.
  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    forever begin
      @(negedge clk);
      if (pready) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  // Bursts of back-to-back transfers separated by random gaps, which may be empty.
  task automatic send_sample(input logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_sample_value <= v;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    @(posedge clk);
    samples_sent++;
  endtask

  // Settings are only changed once every outstanding result has come back.
  task automatic set_shape(input logic [31:0] c, input logic [31:0] w,
                           input logic [31:0] lo, input logic [31:0] hi);
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    reg_write(ADDR_CENTER, c);
    reg_write(ADDR_WIDTH, w);
    reg_write(ADDR_LO_K, lo);
    reg_write(ADDR_HI_K, hi);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    centre_now = c;
    width_now = w;
    settings_used++;
  endtask

  // A sample at a given normalised distance (Q.16) from the peak.
  function automatic logic [31:0] at_sigmas(input longint t);
    longint off;
    off = (t * longint'(width_now[30:0])) >>> FRAC_BITS;
    return 32'(longint'(centre_now) + off);
  endfunction

  task automatic directed_samples();
    send_sample(32'h0000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(centre_now);
    send_sample(centre_now + 32'd1);
    send_sample(centre_now - 32'd1);
    send_sample(at_sigmas(2 <<< 16));
    send_sample(at_sigmas(-(2 <<< 16)));
    send_sample(at_sigmas(5 <<< 16));
    send_sample(at_sigmas(-(5 <<< 16)));
  endtask

  task automatic random_samples(input int count);
    longint t;
    repeat (count) begin
      if ($urandom_range(0, 9) < 7) begin
        t = longint'($urandom_range(0, 20 << 16)) - (10 << 16);
        send_sample(at_sigmas(t));
      end else begin
        send_sample($urandom);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_samples();
    // Flat tails on both sides.
    set_shape(32'd0, 32'd65536, 32'd0, 32'd0);
    directed_samples();
    set_shape(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1048576, 32'd1048576);
    directed_samples();
    set_shape(32'h8000_0000, 32'd1, 32'h001F_FFFF, 32'd0);
    directed_samples();
    // Zero width saturates the distance for every sample off the centre.
    set_shape($urandom, 32'd0, 32'd131072, 32'd65536);
    directed_samples();

    repeat (RANDOM_PHASES) begin
      set_shape($urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 1 << 22)) - 32'd2097152,
                $urandom_range(0, 5) == 0 ? ($urandom & 32'h7FFF_FFFF)
                                          : $urandom_range(1 << 10, 1 << 21),
                $urandom_range(0, 1 << 20), $urandom_range(0, 6 << 16));
      random_samples(ITEMS_PER_PHASE);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("tb: %0d samples over %0d register settings", samples_sent, settings_used);
    $display("tb: low tail %0d, core %0d, high tail %0d", n_low_tail, n_core, n_high_tail);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
